// ===== rtl/wsp_pkg.sv =====
// Shared types, constants and helpers for the world-to-screen projection pipeline.
`default_nettype none

package wsp_pkg;

    localparam int COEF_W     = 32;
    localparam int NUM_COEFS  = 12;
    localparam int VP_W       = 14;
    localparam int SAT_IN_W   = 68;
    localparam int NDC_W      = 49;
    localparam int PROD_W     = 64;

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_PROJECT = 1'b1;

    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    localparam logic [VP_W-1:0] RESET_WIDTH  = 14'd1920;
    localparam logic [VP_W-1:0] RESET_HEIGHT = 14'd1080;

    localparam logic signed [COEF_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COEF_W-1:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [PROD_W-1:0] NDC_LIMIT = 64'sh0000_8000_0000_0000;

    typedef struct packed {
        logic                     w_zero;
        logic                     cx_neg;
        logic                     cy_neg;
        logic signed [COEF_W-1:0] clip_w;
    } t_side;

    function automatic logic signed [COEF_W-1:0] sat32(input logic signed [SAT_IN_W-1:0] v);
        logic fits;
        fits = (&v[SAT_IN_W-1:COEF_W-1]) | ~(|v[SAT_IN_W-1:COEF_W-1]);
        if (fits) begin
            return v[COEF_W-1:0];
        end
        return v[SAT_IN_W-1] ? S32_MIN : S32_MAX;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/wsp_dot.sv =====
// Clip-space dot products: registered products, then row sums with saturation.
`default_nettype none

module wsp_dot import wsp_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_valid,
    input  wire logic signed [COEF_W-1:0] i_coef [NUM_COEFS],
    input  wire logic signed [COEF_W-1:0] i_pos_x,
    input  wire logic signed [COEF_W-1:0] i_pos_y,
    input  wire logic signed [COEF_W-1:0] i_pos_z,
    output logic                          o_valid,
    output logic signed [COEF_W-1:0]      o_cx,
    output logic signed [COEF_W-1:0]      o_cy,
    output t_side                         o_side
);

    localparam int SUM_W = 66 - FRAC_BITS;

    logic signed [COEF_W-1:0] pos [3];
    logic signed [PROD_W-1:0] r_prod [9];
    logic signed [COEF_W-1:0] r_off [3];
    logic                     r_v1;
    logic signed [SUM_W-1:0]  row_sum [3];
    logic signed [COEF_W-1:0] r_cx;
    logic signed [COEF_W-1:0] r_cy;
    t_side                    r_side;
    logic                     r_v2;

    assign pos[0] = i_pos_x;
    assign pos[1] = i_pos_y;
    assign pos[2] = i_pos_z;

    for (genvar r = 0; r < 3; r++) begin : g_row
        for (genvar c = 0; c < 3; c++) begin : g_col
            logic signed [PROD_W-1:0] n_prod;
            assign n_prod = i_coef[4*r+c] * pos[c];
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_prod[3*r+c] <= n_prod;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_off[r] <= i_coef[4*r+3];
            end
        end
        always_comb begin
            logic signed [PROD_W-1:0] t0, t1, t2;
            t0 = r_prod[3*r]   >>> FRAC_BITS;
            t1 = r_prod[3*r+1] >>> FRAC_BITS;
            t2 = r_prod[3*r+2] >>> FRAC_BITS;
            row_sum[r] = SUM_W'(t0) + SUM_W'(t1) + SUM_W'(t2) + SUM_W'(r_off[r]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [COEF_W-1:0] sx, sy;
        if (i_en) begin
            sx = sat32(SAT_IN_W'(row_sum[0]));
            sy = sat32(SAT_IN_W'(row_sum[1]));
            r_cx          <= sx;
            r_cy          <= sy;
            r_side.w_zero <= (row_sum[2] == '0);
            r_side.cx_neg <= sx[COEF_W-1];
            r_side.cy_neg <= sy[COEF_W-1];
            r_side.clip_w <= sat32(SAT_IN_W'(row_sum[2]));
        end
    end

    assign o_valid = r_v2;
    assign o_cx    = r_cx;
    assign o_cy    = r_cy;
    assign o_side  = r_side;

endmodule

`default_nettype wire

// ===== rtl/wsp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, for clip x and y over w.
`default_nettype none

module wsp_div import wsp_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_valid,
    input  wire logic signed [COEF_W-1:0] i_cx,
    input  wire logic signed [COEF_W-1:0] i_cy,
    input  wire t_side                    i_side,
    output logic                          o_valid,
    output logic [COEF_W+FRAC_BITS-1:0]   o_qx,
    output logic [COEF_W+FRAC_BITS-1:0]   o_qy,
    output logic                          o_negx,
    output logic                          o_negy,
    output t_side                         o_side
);

    localparam int NUM_W = COEF_W + FRAC_BITS;

    logic              r_v    [NUM_W+1];
    logic [NUM_W-1:0]  r_nx   [NUM_W+1];
    logic [NUM_W-1:0]  r_ny   [NUM_W+1];
    logic [COEF_W-1:0] r_rx   [NUM_W+1];
    logic [COEF_W-1:0] r_ry   [NUM_W+1];
    logic [COEF_W-1:0] r_d    [NUM_W+1];
    logic              r_negx [NUM_W+1];
    logic              r_negy [NUM_W+1];
    t_side             r_side [NUM_W+1];

    logic [COEF_W-1:0] ax, ay, aw;

    assign ax = i_cx[COEF_W-1] ? (~i_cx + 1'b1) : i_cx;
    assign ay = i_cy[COEF_W-1] ? (~i_cy + 1'b1) : i_cy;
    assign aw = i_side.clip_w[COEF_W-1] ? (~i_side.clip_w + 1'b1) : i_side.clip_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nx[0]   <= {ax, {FRAC_BITS{1'b0}}};
            r_ny[0]   <= {ay, {FRAC_BITS{1'b0}}};
            r_rx[0]   <= '0;
            r_ry[0]   <= '0;
            r_d[0]    <= aw;
            r_negx[0] <= i_cx[COEF_W-1] ^ i_side.clip_w[COEF_W-1];
            r_negy[0] <= i_cy[COEF_W-1] ^ i_side.clip_w[COEF_W-1];
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [COEF_W:0]   shx, shy;
        logic              gex, gey;
        logic [COEF_W-1:0] n_rx, n_ry;

        always_comb begin
            shx  = {r_rx[k], r_nx[k][NUM_W-1]};
            shy  = {r_ry[k], r_ny[k][NUM_W-1]};
            gex  = (shx >= {1'b0, r_d[k]});
            gey  = (shy >= {1'b0, r_d[k]});
            n_rx = gex ? COEF_W'(shx - {1'b0, r_d[k]}) : COEF_W'(shx);
            n_ry = gey ? COEF_W'(shy - {1'b0, r_d[k]}) : COEF_W'(shy);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nx[k+1]   <= {r_nx[k][NUM_W-2:0], gex};
                r_ny[k+1]   <= {r_ny[k][NUM_W-2:0], gey};
                r_rx[k+1]   <= n_rx;
                r_ry[k+1]   <= n_ry;
                r_d[k+1]    <= r_d[k];
                r_negx[k+1] <= r_negx[k];
                r_negy[k+1] <= r_negy[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_v[NUM_W];
    assign o_qx    = r_nx[NUM_W];
    assign o_qy    = r_ny[NUM_W];
    assign o_negx  = r_negx[NUM_W];
    assign o_negy  = r_negy[NUM_W];
    assign o_side  = r_side[NUM_W];

endmodule

`default_nettype wire

// ===== rtl/wsp_map.sv =====
// Viewport mapping: sign and clamp of the quotients, scaling, offset, zero-w saturation and output register.
`default_nettype none

module wsp_map import wsp_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic [COEF_W+FRAC_BITS-1:0]   i_qx,
    input  wire logic [COEF_W+FRAC_BITS-1:0]   i_qy,
    input  wire logic                          i_negx,
    input  wire logic                          i_negy,
    input  wire t_side                         i_side,
    input  wire logic [VP_W-1:0]               i_width,
    input  wire logic [VP_W-1:0]               i_height,
    output logic                               o_valid,
    output logic signed [COEF_W-1:0]           o_screen_x,
    output logic signed [COEF_W-1:0]           o_screen_y,
    output logic signed [COEF_W-1:0]           o_clip_w,
    output logic                               o_w_zero
);

    localparam logic signed [PROD_W-1:0] ONE = 64'sd1 <<< FRAC_BITS;

    logic signed [PROD_W-1:0] vx, vy;
    logic signed [NDC_W-1:0]  r_ndx, r_ndy;
    t_side                    r_side_a, r_side_b;
    logic                     r_va, r_vb, r_vc;
    logic signed [PROD_W-1:0] r_px, r_py;
    logic signed [PROD_W-1:0] sum_x, sum_y;
    logic signed [COEF_W-1:0] r_sx, r_sy, r_cw;
    logic                     r_wz;

    always_comb begin
        vx = i_negx ? -PROD_W'(i_qx) : PROD_W'(i_qx);
        vy = i_negy ? -PROD_W'(i_qy) : PROD_W'(i_qy);
        if (vx > NDC_LIMIT) begin
            vx = NDC_LIMIT;
        end else if (vx < -NDC_LIMIT) begin
            vx = -NDC_LIMIT;
        end
        if (vy > NDC_LIMIT) begin
            vy = NDC_LIMIT;
        end else if (vy < -NDC_LIMIT) begin
            vy = -NDC_LIMIT;
        end
    end

    always_comb begin
        sum_x = (($signed(PROD_W'(i_width)) <<< FRAC_BITS) + r_px + ONE) >>> 1;
        sum_y = (($signed(PROD_W'(i_height)) <<< FRAC_BITS) - r_py - ONE) >>> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ndx    <= NDC_W'(vx);
            r_ndy    <= NDC_W'(vy);
            r_side_a <= i_side;
            r_px     <= r_ndx * $signed({1'b0, i_width});
            r_py     <= r_ndy * $signed({1'b0, i_height});
            r_side_b <= r_side_a;
            r_wz     <= r_side_b.w_zero;
            r_cw     <= r_side_b.clip_w;
            if (r_side_b.w_zero) begin
                r_sx <= r_side_b.cx_neg ? S32_MIN : S32_MAX;
                r_sy <= r_side_b.cy_neg ? S32_MAX : S32_MIN;
            end else begin
                r_sx <= sat32(SAT_IN_W'(sum_x));
                r_sy <= sat32(SAT_IN_W'(sum_y));
            end
        end
    end

    assign o_valid    = r_vc;
    assign o_screen_x = r_sx;
    assign o_screen_y = r_sy;
    assign o_clip_w   = r_cw;
    assign o_w_zero   = r_wz;

endmodule

`default_nettype wire

// ===== rtl/world_to_screen_projection.sv =====
// Top level: coefficient store, viewport registers, APB port and pipeline control.
// Each item passes the dot-product, divider and mapping pipelines in order; the divider gives one bit per stage.
// Throughput is one item per cycle; the whole pipeline holds while a result waits unaccepted.
// Load items with an index below 12 write the coefficient store in the cycle they are accepted and give no result.
// Reset is synchronous and active low; it clears valid bits and sets viewport 1920 by 1080.
// The coefficient store has no reset and must be loaded before projecting.
`default_nettype none

module world_to_screen_projection import wsp_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic                     i_kind,
    input  wire logic [3:0]               i_coef_index,
    input  wire logic signed [COEF_W-1:0] i_coef_value,
    input  wire logic signed [COEF_W-1:0] i_pos_x,
    input  wire logic signed [COEF_W-1:0] i_pos_y,
    input  wire logic signed [COEF_W-1:0] i_pos_z,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic signed [COEF_W-1:0]      o_screen_x,
    output logic signed [COEF_W-1:0]      o_screen_y,
    output logic signed [COEF_W-1:0]      o_clip_w,
    output logic                          o_w_zero,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [2:0]               paddr,
    input  wire logic [31:0]              pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int NUM_W = COEF_W + FRAC_BITS;

    logic                     en;
    logic                     in_acc;
    logic signed [COEF_W-1:0] r_coef [NUM_COEFS];
    logic [VP_W-1:0]          r_width;
    logic [VP_W-1:0]          r_height;

    logic                     dot_valid;
    logic signed [COEF_W-1:0] dot_cx, dot_cy;
    t_side                    dot_side;
    logic                     div_valid;
    logic [NUM_W-1:0]         div_qx, div_qy;
    logic                     div_negx, div_negy;
    t_side                    div_side;

    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;
    assign in_acc     = i_in_valid && en;
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == REG_HEIGHT) ? 32'(r_height) : 32'(r_width);

    always_ff @(posedge i_clk) begin
        if (in_acc && i_kind == KIND_LOAD && i_coef_index < 4'(NUM_COEFS)) begin
            r_coef[i_coef_index] <= i_coef_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RESET_WIDTH;
            r_height <= RESET_HEIGHT;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                REG_WIDTH:  r_width  <= pwdata[VP_W-1:0];
                REG_HEIGHT: r_height <= pwdata[VP_W-1:0];
                default:    r_width  <= r_width;
            endcase
        end
    end

    wsp_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid && i_kind == KIND_PROJECT),
        .i_coef  (r_coef),
        .i_pos_x (i_pos_x),
        .i_pos_y (i_pos_y),
        .i_pos_z (i_pos_z),
        .o_valid (dot_valid),
        .o_cx    (dot_cx),
        .o_cy    (dot_cy),
        .o_side  (dot_side)
    );

    wsp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (dot_valid),
        .i_cx    (dot_cx),
        .i_cy    (dot_cy),
        .i_side  (dot_side),
        .o_valid (div_valid),
        .o_qx    (div_qx),
        .o_qy    (div_qy),
        .o_negx  (div_negx),
        .o_negy  (div_negy),
        .o_side  (div_side)
    );

    wsp_map #(.FRAC_BITS(FRAC_BITS)) u_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (div_valid),
        .i_qx       (div_qx),
        .i_qy       (div_qy),
        .i_negx     (div_negx),
        .i_negy     (div_negy),
        .i_side     (div_side),
        .i_width    (r_width),
        .i_height   (r_height),
        .o_valid    (o_out_valid),
        .o_screen_x (o_screen_x),
        .o_screen_y (o_screen_y),
        .o_clip_w   (o_clip_w),
        .o_w_zero   (o_w_zero)
    );

    a_zero_w_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_w_zero |-> o_clip_w == '0)
        else $error("Zero w result carries a nonzero clip w.");

    a_zero_w_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_w_zero |->
            (o_screen_x == S32_MAX || o_screen_x == S32_MIN) &&
            (o_screen_y == S32_MAX || o_screen_y == S32_MIN))
        else $error("Zero w result is not saturated.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Result valid right after reset.");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready ##1
            (o_out_valid && $stable(o_screen_x) && $stable(o_screen_y) &&
             $stable(o_clip_w) && $stable(o_w_zero)))
        else $error("Pipeline moved while a result was stalled.");

endmodule

`default_nettype wire
